// ----- hw/rtl/bbd_pkg.sv -----
// Shared constants and types for the bilinear Bayer demosaic block.
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

    localparam int MAX_WIDTH = 512;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CFG_W     = 10;
    localparam int ROW_W     = 10;
    // width for column compares: holds MAX_WIDTH and any register value
    localparam int CNT_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int PIX_W     = 8;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [CNT_W-1:0] MAX_WIDTH_C = CNT_W'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] MIN_WIDTH_C = CNT_W'(3);
    localparam logic [ROW_W-1:0] MIN_HEIGHT_C = ROW_W'(3);

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(320);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(200);

    // register index, taken from paddr[2]
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef struct packed {
        logic             rd_en;
        logic [COL_W-1:0] rd_addr;
        logic             wr_en;
        logic [COL_W-1:0] wr_addr;
        logic [PIX_W-1:0] wr_sample;
    } lb_req_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bbd_line_buf.sv -----
// Two line stores with registered read and same-cycle write bypass.
`timescale 1ns / 1ps
`default_nettype none

module bbd_line_buf (
    input  wire logic                   aclk,
    input  wire bbd_pkg::lb_req_t       req,
    output logic [bbd_pkg::PIX_W-1:0]   up_q,
    output logic [bbd_pkg::PIX_W-1:0]   mid_q
);

    logic [bbd_pkg::PIX_W-1:0] upper_mem [bbd_pkg::MAX_WIDTH];
    logic [bbd_pkg::PIX_W-1:0] middle_mem [bbd_pkg::MAX_WIDTH];

    logic [bbd_pkg::PIX_W-1:0] up_rd_reg;
    logic [bbd_pkg::PIX_W-1:0] mid_rd_reg;
    logic [bbd_pkg::PIX_W-1:0] byp_up_reg;
    logic [bbd_pkg::PIX_W-1:0] byp_mid_reg;
    logic                      hit_reg;

    // the item being written shifts its middle value up and its sample in
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            upper_mem[req.wr_addr]  <= mid_q;
            middle_mem[req.wr_addr] <= req.wr_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            up_rd_reg   <= upper_mem[req.rd_addr];
            mid_rd_reg  <= middle_mem[req.rd_addr];
            byp_up_reg  <= mid_q;
            byp_mid_reg <= req.wr_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            hit_reg <= req.wr_en && (req.wr_addr == req.rd_addr);
        end
    end

    assign up_q  = hit_reg ? byp_up_reg  : up_rd_reg;
    assign mid_q = hit_reg ? byp_mid_reg : mid_rd_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bayer_bilinear_demosaic_core.sv -----
// Top level of the 3x3 bilinear Bayer demosaic.
//
// Input stream: one 8-bit raw sample per transfer in row-major order on
// s_axis_tdata; s_axis_tuser marks the first sample of a frame and restarts
// the row and column counters. Output stream: one RGB pixel per interior
// pixel (border pixels give nothing), red in the low byte of m_axis_tdata;
// m_axis_tlast marks the last pixel of an output row and m_axis_tuser the
// last pixel of the frame. Frame width and height are set over APB at
// byte addresses 0 and 4; the user must set them only while the stream is
// idle, which the block does not enforce. Throughput: one sample per cycle
// while the receiver does not stall. The pixel centered one row and one
// column back comes from the sample completing its window: line store read
// of that sample's column, then interpolation into the output register.
// Reset clears counters, window and handshakes; the line stores are not
// cleared and need two rows of a frame before any pixel is emitted.
// When the receiver stalls, the output register holds, the pipeline freezes
// and s_axis_tready drops in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module bayer_bilinear_demosaic_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // APB configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [bbd_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [bbd_pkg::DATA_W-1:0]    pwdata,
    output logic      [bbd_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    // raw samples
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [7:0]                    s_axis_tdata,  // [7:0] raw_sample
    input  wire logic                          s_axis_tuser,  // frame_start
    // RGB pixels
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [23:0]                        m_axis_tdata,  // blue, green, red
    output logic                               m_axis_tlast,  // row_end
    output logic                               m_axis_tuser   // frame_end
);

    localparam int COL_W = bbd_pkg::COL_W;
    localparam int ROW_W = bbd_pkg::ROW_W;
    localparam int CNT_W = bbd_pkg::CNT_W;
    localparam int PIX_W = bbd_pkg::PIX_W;

    // ---------------- configuration ----------------
    logic [bbd_pkg::CFG_W-1:0] frame_width_reg;
    logic [bbd_pkg::CFG_W-1:0] frame_height_reg;
    logic                      cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bbd_pkg::WIDTH_RESET;
            frame_height_reg <= bbd_pkg::HEIGHT_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                bbd_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[bbd_pkg::CFG_W-1:0];
                bbd_pkg::REG_FRAME_HEIGHT: frame_height_reg <= pwdata[bbd_pkg::CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            bbd_pkg::REG_FRAME_WIDTH:
                prdata = bbd_pkg::DATA_W'(frame_width_reg);
            bbd_pkg::REG_FRAME_HEIGHT:
                prdata = bbd_pkg::DATA_W'(frame_height_reg);
            default: prdata = '0;
        endcase
    end

    logic [CNT_W-1:0] w_eff;
    logic [ROW_W-1:0] h_eff;

    always_comb begin
        w_eff = CNT_W'(frame_width_reg);
        if (w_eff < bbd_pkg::MIN_WIDTH_C) begin
            w_eff = bbd_pkg::MIN_WIDTH_C;
        end else if (w_eff > bbd_pkg::MAX_WIDTH_C) begin
            w_eff = bbd_pkg::MAX_WIDTH_C;
        end
        h_eff = frame_height_reg;
        if (h_eff < bbd_pkg::MIN_HEIGHT_C) begin
            h_eff = bbd_pkg::MIN_HEIGHT_C;
        end
    end

    // ---------------- handshake ----------------
    logic m_valid_reg;
    logic s1_valid_reg;
    logic advance;
    logic accept;

    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;
    assign accept        = s_axis_tvalid && advance;

    // ---------------- position counters ----------------
    logic [COL_W-1:0] col_cnt_reg, col_cnt_next;
    logic [ROW_W-1:0] row_cnt_reg, row_cnt_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic [CNT_W-1:0] col_inc;
    logic             emit_cur;
    logic             row_end_cur;
    logic             frame_end_cur;

    always_comb begin
        // wrap before placing: frame start, or limits shrunk mid-frame
        col_cur = col_cnt_reg;
        row_cur = row_cnt_reg;
        if (s_axis_tuser) begin
            col_cur = '0;
            row_cur = '0;
        end else if (CNT_W'(col_cnt_reg) >= w_eff) begin
            col_cur = '0;
            row_cur = row_cnt_reg + ROW_W'(1);
        end
        if (row_cur >= h_eff) begin
            row_cur = '0;
        end

        col_inc      = CNT_W'(col_cur) + CNT_W'(1);
        col_cnt_next = col_inc[COL_W-1:0];
        row_cnt_next = row_cur;
        if (col_inc >= w_eff) begin
            col_cnt_next = '0;
            row_cnt_next = row_cur + ROW_W'(1);
            if (row_cnt_next >= h_eff) begin
                row_cnt_next = '0;
            end
        end

        emit_cur      = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
        row_end_cur   = (CNT_W'(col_cur) == w_eff - CNT_W'(1));
        frame_end_cur = row_end_cur && (row_cur == h_eff - ROW_W'(1));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end else if (accept) begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ---------------- stage 1: line store read ----------------
    logic [PIX_W-1:0] s1_sample_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic             s1_emit_reg;
    logic             s1_x_odd_reg;
    logic             s1_y_odd_reg;
    logic             s1_row_end_reg;
    logic             s1_frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_sample_reg    <= s_axis_tdata;
            s1_addr_reg      <= col_cur;
            s1_emit_reg      <= emit_cur;
            // center pixel sits one column and one row back
            s1_x_odd_reg     <= ~col_cur[0];
            s1_y_odd_reg     <= ~row_cur[0];
            s1_row_end_reg   <= row_end_cur;
            s1_frame_end_reg <= frame_end_cur;
        end
    end

    bbd_pkg::lb_req_t lb_req;
    logic [PIX_W-1:0] up_q;
    logic [PIX_W-1:0] mid_q;
    logic             s1_move;

    assign s1_move = advance && s1_valid_reg;

    always_comb begin
        lb_req.rd_en     = accept;
        lb_req.rd_addr   = col_cur;
        lb_req.wr_en     = s1_move;
        lb_req.wr_addr   = s1_addr_reg;
        lb_req.wr_sample = s1_sample_reg;
    end

    bbd_line_buf u_line_buf (
        .aclk  (aclk),
        .req   (lb_req),
        .up_q  (up_q),
        .mid_q (mid_q)
    );

    // ---------------- window ----------------
    // win2: column col-2, win1: column col-1; index 0 is the top row
    logic [PIX_W-1:0] win2_reg [3];
    logic [PIX_W-1:0] win1_reg [3];
    logic [PIX_W-1:0] cur_col [3];

    always_comb begin
        cur_col[0] = up_q;
        cur_col[1] = mid_q;
        cur_col[2] = s1_sample_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                win2_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end else if (s1_move) begin
            for (int i = 0; i < 3; i++) begin
                win2_reg[i] <= win1_reg[i];
                win1_reg[i] <= cur_col[i];
            end
        end
    end

    // ---------------- interpolation ----------------
    logic [PIX_W+1:0] cross_sum;
    logic [PIX_W+1:0] diag_sum;
    logic [PIX_W:0]   horiz_sum;
    logic [PIX_W:0]   vert_sum;
    logic [PIX_W-1:0] red_d, green_d, blue_d;
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] cross_avg, diag_avg, horiz_avg, vert_avg;

    always_comb begin
        center    = win1_reg[1];
        horiz_sum = {1'b0, win2_reg[1]} + {1'b0, cur_col[1]};
        vert_sum  = {1'b0, win1_reg[0]} + {1'b0, win1_reg[2]};
        cross_sum = {1'b0, horiz_sum} + {1'b0, vert_sum};
        diag_sum  = (PIX_W+2)'(win2_reg[0]) + (PIX_W+2)'(cur_col[0])
                  + (PIX_W+2)'(win2_reg[2]) + (PIX_W+2)'(cur_col[2]);
        cross_avg = cross_sum[PIX_W+1:2];
        diag_avg  = diag_sum[PIX_W+1:2];
        horiz_avg = horiz_sum[PIX_W:1];
        vert_avg  = vert_sum[PIX_W:1];

        unique case ({s1_y_odd_reg, s1_x_odd_reg})
            2'b11: begin  // red site
                red_d   = center;
                green_d = cross_avg;
                blue_d  = diag_avg;
            end
            2'b10: begin  // green on a red row
                red_d   = horiz_avg;
                green_d = center;
                blue_d  = vert_avg;
            end
            2'b01: begin  // green on a blue row
                red_d   = vert_avg;
                green_d = center;
                blue_d  = horiz_avg;
            end
            default: begin  // blue site
                red_d   = diag_avg;
                green_d = cross_avg;
                blue_d  = center;
            end
        endcase
    end

    // ---------------- output register ----------------
    logic [23:0] m_data_reg;
    logic        m_last_reg;
    logic        m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move && s1_emit_reg) begin
            m_data_reg <= {blue_d, green_d, red_d};
            m_last_reg <= s1_row_end_reg;
            m_user_reg <= s1_frame_end_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bbd_checker.sv -----
// Port-level checks for the demosaic core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bbd_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        pready,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [23:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic        m_axis_tuser
);

    // a stalled output transfer keeps its pixel
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // frame end is always also a row end
    a_frame_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without row end");

    // input ready is high whenever the output register is free or drains
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
        else $error("input stalled without output backpressure");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid || !s_axis_tvalid |-> pready)
        else $error("pready low");

endmodule

bind bayer_bilinear_demosaic_core bbd_checker u_bbd_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
